/* hdl/cbt_pkg.sv */
package cbt_pkg;

    // Field widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned MARGIN_W = 9;
    localparam int unsigned ROW_W    = 10;
    localparam int unsigned COL_W    = 10;
    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned SUM_W    = 30;
    localparam int unsigned CNT_W    = 21;
    localparam int unsigned MEAN_W   = 10;

    // Frame limits; pixels outside are not accumulated
    localparam int unsigned MAX_ROWS = 1024;
    localparam int unsigned MAX_COLS = 1024;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    // Frame totals queue between front and back
    localparam int unsigned Q_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAD_RED     = 3'd0,
        REG_HEAD_GREEN   = 3'd1,
        REG_HEAD_BLUE    = 3'd2,
        REG_TAIL_RED     = 3'd3,
        REG_TAIL_GREEN   = 3'd4,
        REG_TAIL_BLUE    = 3'd5,
        REG_MATCH_MARGIN = 3'd6,
        REG_FRAME_WIDTH  = 3'd7
    } t_cfg_reg;

    // Division jobs, in the order the back end runs them
    typedef enum logic [1:0] {
        OP_HEAD_ROW = 2'd0,
        OP_HEAD_COL = 2'd1,
        OP_TAIL_ROW = 2'd2,
        OP_TAIL_COL = 2'd3
    } t_op;

    typedef struct packed {
        logic [CHAN_W-1:0] pix_blue;
        logic [CHAN_W-1:0] pix_green;
        logic [CHAN_W-1:0] pix_red;
        logic [ROW_W-1:0]  pix_row;
        logic [COL_W-1:0]  pix_col;
        logic              frame_end;
    } t_pix;

    typedef struct packed {
        logic [MEAN_W-1:0]  head_row;
        logic [WIDTH_W-1:0] head_col;
        logic [MEAN_W-1:0]  tail_row;
        logic [WIDTH_W-1:0] tail_col;
        logic [MEAN_W-1:0]  mid_row;
        logic [WIDTH_W-1:0] mid_col;
        logic               head_found;
        logic               tail_found;
    } t_result;

    typedef struct packed {
        logic [CHAN_W-1:0]   head_red;
        logic [CHAN_W-1:0]   head_green;
        logic [CHAN_W-1:0]   head_blue;
        logic [CHAN_W-1:0]   tail_red;
        logic [CHAN_W-1:0]   tail_green;
        logic [CHAN_W-1:0]   tail_blue;
        logic [MARGIN_W-1:0] match_margin;
        logic [WIDTH_W-1:0]  frame_width;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] head_row_sum;
        logic [SUM_W-1:0] head_col_sum;
        logic [CNT_W-1:0] head_count;
        logic [SUM_W-1:0] tail_row_sum;
        logic [SUM_W-1:0] tail_col_sum;
        logic [CNT_W-1:0] tail_count;
    } t_totals;

    // |pix - ref| < margin, same as ref - margin < pix < ref + margin
    function automatic logic chan_near(
        input logic [CHAN_W-1:0]   pix,
        input logic [CHAN_W-1:0]   ref_lvl,
        input logic [MARGIN_W-1:0] margin
    );
        logic [CHAN_W:0] diff;
        logic [CHAN_W:0] mag;
        diff = {1'b0, pix} - {1'b0, ref_lvl};
        mag  = diff[CHAN_W] ? (~diff + 1'b1) : diff;
        return mag < margin;
    endfunction

endpackage

/* hdl/color_blob_centroid_tracker.sv */
// Channel   Handshake       Payload        Beat taken when
// pixel     i_push/o_full   i_pix          i_push && !o_full
// result    o_empty/i_pop   o_res          i_pop && !o_empty
// config    i_cfg_we        i_cfg_idx/data i_cfg_we
//
// The front takes one pixel beat every clock while o_full is low, matching and summing
// in that cycle. Each frame end result is built after its totals leave the queue: four
// divisions on one shared divider that resolves one bit per cycle, plus mirror and
// output steps.
// The totals queue holds two frames; o_full rises only while both entries wait.
// Reset is synchronous: it clears sums, queue, output and restores register defaults.
module color_blob_centroid_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  cbt_pkg::t_pix                      i_pix,
    output logic                               o_empty,
    input  logic                               i_pop,
    output cbt_pkg::t_result                   o_res,
    input  logic                               i_cfg_we,
    input  logic [cbt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cbt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    cbt_pkg::t_cfg    r_cfg;
    logic             accept;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    cbt_pkg::t_totals q_wdata;
    cbt_pkg::t_totals q_rdata;

    // Decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_red     <= '0;
            r_cfg.head_green   <= '0;
            r_cfg.head_blue    <= '0;
            r_cfg.tail_red     <= '0;
            r_cfg.tail_green   <= '0;
            r_cfg.tail_blue    <= '0;
            r_cfg.match_margin <= cbt_pkg::MARGIN_W'(16);
            r_cfg.frame_width  <= cbt_pkg::WIDTH_W'(640);
        end else if (i_cfg_we) begin
            case (cbt_pkg::t_cfg_reg'(i_cfg_idx))
                cbt_pkg::REG_HEAD_RED:     r_cfg.head_red     <= i_cfg_data[cbt_pkg::CHAN_W-1:0];
                cbt_pkg::REG_HEAD_GREEN:   r_cfg.head_green   <= i_cfg_data[cbt_pkg::CHAN_W-1:0];
                cbt_pkg::REG_HEAD_BLUE:    r_cfg.head_blue    <= i_cfg_data[cbt_pkg::CHAN_W-1:0];
                cbt_pkg::REG_TAIL_RED:     r_cfg.tail_red     <= i_cfg_data[cbt_pkg::CHAN_W-1:0];
                cbt_pkg::REG_TAIL_GREEN:   r_cfg.tail_green   <= i_cfg_data[cbt_pkg::CHAN_W-1:0];
                cbt_pkg::REG_TAIL_BLUE:    r_cfg.tail_blue    <= i_cfg_data[cbt_pkg::CHAN_W-1:0];
                cbt_pkg::REG_MATCH_MARGIN: r_cfg.match_margin <= i_cfg_data[cbt_pkg::MARGIN_W-1:0];
                cbt_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[cbt_pkg::WIDTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Take a pixel whenever the totals queue has room
    assign o_full = q_full;
    assign accept = i_push && !q_full;

    cbt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pix    (i_pix),
        .i_cfg    (r_cfg),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    cbt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    cbt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_frame_width (r_cfg.frame_width),
        .o_res         (o_res),
        .o_empty       (o_empty),
        .i_pop         (i_pop)
    );

endmodule

/* hdl/cbt_front.sv */
module cbt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  cbt_pkg::t_pix    i_pix,
    input  cbt_pkg::t_cfg    i_cfg,
    output logic             o_q_push,
    output cbt_pkg::t_totals o_q_data
);

    cbt_pkg::t_totals r_acc;
    cbt_pkg::t_totals n_acc;
    logic             in_frame;
    logic             head_hit;
    logic             tail_hit;

    // Classify the pixel against both markers
    always_comb begin
        in_frame = (32'(i_pix.pix_row) < 32'(cbt_pkg::MAX_ROWS)) &&
                   (32'(i_pix.pix_col) < 32'(cbt_pkg::MAX_COLS));
        head_hit = in_frame &&
                   cbt_pkg::chan_near(i_pix.pix_blue,  i_cfg.head_blue,  i_cfg.match_margin) &&
                   cbt_pkg::chan_near(i_pix.pix_green, i_cfg.head_green, i_cfg.match_margin) &&
                   cbt_pkg::chan_near(i_pix.pix_red,   i_cfg.head_red,   i_cfg.match_margin);
        tail_hit = in_frame &&
                   cbt_pkg::chan_near(i_pix.pix_blue,  i_cfg.tail_blue,  i_cfg.match_margin) &&
                   cbt_pkg::chan_near(i_pix.pix_green, i_cfg.tail_green, i_cfg.match_margin) &&
                   cbt_pkg::chan_near(i_pix.pix_red,   i_cfg.tail_red,   i_cfg.match_margin);
    end

    // Add the pixel into the sums of each marker it matches
    always_comb begin
        n_acc = r_acc;
        if (head_hit) begin
            n_acc.head_row_sum = r_acc.head_row_sum + cbt_pkg::SUM_W'(i_pix.pix_row);
            n_acc.head_col_sum = r_acc.head_col_sum + cbt_pkg::SUM_W'(i_pix.pix_col);
            n_acc.head_count   = r_acc.head_count + 1'b1;
        end
        if (tail_hit) begin
            n_acc.tail_row_sum = r_acc.tail_row_sum + cbt_pkg::SUM_W'(i_pix.pix_row);
            n_acc.tail_col_sum = r_acc.tail_col_sum + cbt_pkg::SUM_W'(i_pix.pix_col);
            n_acc.tail_count   = r_acc.tail_count + 1'b1;
        end
    end

    // Hand the frame totals over on the last pixel and start a fresh frame
    assign o_q_push = i_accept && i_pix.frame_end;
    assign o_q_data = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_accept) begin
            r_acc <= i_pix.frame_end ? '0 : n_acc;
        end
    end

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_pix.frame_end |=> r_acc == '0)
        else $error("accumulators not cleared after frame end");

endmodule

/* hdl/cbt_fifo.sv */
module cbt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cbt_pkg::t_totals i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output cbt_pkg::t_totals o_data
);

    localparam int unsigned PTR_W = (cbt_pkg::Q_DEPTH > 1) ? $clog2(cbt_pkg::Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(cbt_pkg::Q_DEPTH + 1);

    cbt_pkg::t_totals r_mem [cbt_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(cbt_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(cbt_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(cbt_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("frame totals pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("frame totals popped from an empty queue");

endmodule

/* hdl/cbt_back.sv */
module cbt_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  cbt_pkg::t_totals                i_q_data,
    output logic                            o_q_pop,
    input  logic [cbt_pkg::WIDTH_W-1:0]     i_frame_width,
    output cbt_pkg::t_result                o_res,
    output logic                            o_empty,
    input  logic                            i_pop
);

    localparam int unsigned BIT_W = $clog2(cbt_pkg::SUM_W);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_MIRROR = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state                        r_state;
    cbt_pkg::t_op                  r_op;
    cbt_pkg::t_totals              r_job;
    logic [cbt_pkg::CNT_W-1:0]     r_rem;
    logic [cbt_pkg::SUM_W-1:0]     r_quo;
    logic [BIT_W-1:0]              r_bit;
    logic [cbt_pkg::MEAN_W-1:0]    r_mean [4];
    logic [cbt_pkg::MEAN_W-1:0]    r_hr;
    logic [cbt_pkg::MEAN_W-1:0]    r_tr;
    logic [cbt_pkg::WIDTH_W-1:0]   r_hc;
    logic [cbt_pkg::WIDTH_W-1:0]   r_tc;
    logic                          r_hf;
    logic                          r_tf;
    cbt_pkg::t_result              r_out;
    logic                          r_out_valid;

    logic [cbt_pkg::SUM_W-1:0]     dividend;
    logic [cbt_pkg::CNT_W-1:0]     divisor;
    logic [cbt_pkg::CNT_W:0]       rem_sh;
    logic                          rem_ge;
    logic [cbt_pkg::CNT_W-1:0]     n_rem;
    logic [cbt_pkg::SUM_W-1:0]     n_quo;
    logic [cbt_pkg::MEAN_W-1:0]    mean_sat;
    logic                          hf;
    logic                          tf;
    logic [cbt_pkg::WIDTH_W-1:0]   hc_mir;
    logic [cbt_pkg::WIDTH_W-1:0]   tc_mir;
    logic [cbt_pkg::MEAN_W:0]      row_pair;
    logic [cbt_pkg::WIDTH_W:0]     col_pair;
    logic                          emit_fire;

    // Pick the operands of the current division
    always_comb begin
        case (r_op)
            cbt_pkg::OP_HEAD_ROW: dividend = r_job.head_row_sum;
            cbt_pkg::OP_HEAD_COL: dividend = r_job.head_col_sum;
            cbt_pkg::OP_TAIL_ROW: dividend = r_job.tail_row_sum;
            cbt_pkg::OP_TAIL_COL: dividend = r_job.tail_col_sum;
            default:              dividend = '0;
        endcase
        divisor = r_op[1] ? r_job.tail_count : r_job.head_count;
    end

    // One restoring division step: one quotient bit per cycle
    always_comb begin
        rem_sh   = {r_rem, r_quo[cbt_pkg::SUM_W-1]};
        rem_ge   = rem_sh >= {1'b0, divisor};
        n_rem    = rem_ge ? cbt_pkg::CNT_W'(rem_sh - {1'b0, divisor})
                          : rem_sh[cbt_pkg::CNT_W-1:0];
        n_quo    = {r_quo[cbt_pkg::SUM_W-2:0], rem_ge};
        mean_sat = (|n_quo[cbt_pkg::SUM_W-1:cbt_pkg::MEAN_W]) ? '1
                                                              : n_quo[cbt_pkg::MEAN_W-1:0];
    end

    // Mirror the mean columns, floor at zero
    always_comb begin
        hf = (r_job.head_count != '0);
        tf = (r_job.tail_count != '0);
        hc_mir = ({1'b0, r_mean[cbt_pkg::OP_HEAD_COL]} > i_frame_width) ? '0
               : i_frame_width - {1'b0, r_mean[cbt_pkg::OP_HEAD_COL]};
        tc_mir = ({1'b0, r_mean[cbt_pkg::OP_TAIL_COL]} > i_frame_width) ? '0
               : i_frame_width - {1'b0, r_mean[cbt_pkg::OP_TAIL_COL]};
        row_pair = {1'b0, r_hr} + {1'b0, r_tr};
        col_pair = {1'b0, r_hc} + {1'b0, r_tc};
    end

    assign o_q_pop   = (r_state == ST_IDLE) && !i_q_empty;
    assign emit_fire = (r_state == ST_EMIT) && (!r_out_valid || i_pop);

    // Sequence the four divisions of a frame, then build the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= cbt_pkg::OP_HEAD_ROW;
            r_bit   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_op    <= cbt_pkg::OP_HEAD_ROW;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_bit   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_bit == BIT_W'(cbt_pkg::SUM_W - 1)) begin
                        if (r_op == cbt_pkg::OP_TAIL_COL) begin
                            r_state <= ST_MIRROR;
                        end else begin
                            r_op    <= cbt_pkg::t_op'(r_op + 2'd1);
                            r_state <= ST_SETUP;
                        end
                    end else begin
                        r_bit <= r_bit + 1'b1;
                    end
                end
                ST_MIRROR: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_data;
        end
        if (r_state == ST_SETUP) begin
            r_rem <= '0;
            r_quo <= dividend;
        end
        if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_bit == BIT_W'(cbt_pkg::SUM_W - 1)) begin
                r_mean[r_op] <= mean_sat;
            end
        end
        if (r_state == ST_MIRROR) begin
            r_hf <= hf;
            r_tf <= tf;
            r_hr <= hf ? r_mean[cbt_pkg::OP_HEAD_ROW] : '0;
            r_tr <= tf ? r_mean[cbt_pkg::OP_TAIL_ROW] : '0;
            r_hc <= hf ? hc_mir : '0;
            r_tc <= tf ? tc_mir : '0;
        end
        if (emit_fire) begin
            r_out.head_row   <= r_hr;
            r_out.head_col   <= r_hc;
            r_out.tail_row   <= r_tr;
            r_out.tail_col   <= r_tc;
            r_out.mid_row    <= row_pair[cbt_pkg::MEAN_W:1];
            r_out.mid_col    <= col_pair[cbt_pkg::WIDTH_W:1];
            r_out.head_found <= r_hf;
            r_out.tail_found <= r_tf;
        end
    end

    // Hold the result until it is popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res   = r_out;
    assign o_empty = !r_out_valid;

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_bit < BIT_W'(cbt_pkg::SUM_W))
        else $error("divider step counter out of range");

    a_missing_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.head_found |-> r_out.head_row == '0 && r_out.head_col == '0)
        else $error("head centroid not zero while head marker missing");

endmodule

/* bench/color_blob_centroid_tracker_tb.sv */
`timescale 1ns / 1ps

module color_blob_centroid_tracker_tb;
    import cbt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // divider pass plus queue and output steps, with margin
    localparam int unsigned SETTLE_CYCLES = 160;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_PIXELS  = 75;
    localparam int unsigned POP_HOLD      = 600;

    typedef struct {
        bit                    is_cfg;
        t_cfg_reg              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_pix                  px;
        bit                    typed;
        t_result               want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    logic                  o_full;
    t_pix                  i_pix;
    logic                  o_empty;
    logic                  i_pop;
    t_result               o_res;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // tracker copy: marker settings and running frame totals
    t_cfg      marker_regs;
    t_totals   frame_acc;
    t_result   frame_results_q[$];
    t_plan_row plan[$];

    int unsigned faults;
    int unsigned pixels_sent;
    int unsigned frames_checked;
    int unsigned head_frames;
    int unsigned tail_frames;
    int unsigned cycle_count;
    bit          hold_pop_req;

    color_blob_centroid_tracker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_pix      (i_pix),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tracker copy

    function automatic bit chan_close(logic [CHAN_W-1:0] pix, logic [CHAN_W-1:0] lvl);
        int d;
        int m;
        d = int'(pix) - int'(lvl);
        m = int'(marker_regs.match_margin);
        return (d > -m) && (d < m);
    endfunction

    function automatic bit marker_hit(t_pix px, logic [CHAN_W-1:0] r,
                                      logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
        return chan_close(px.pix_red, r) && chan_close(px.pix_green, g) &&
               chan_close(px.pix_blue, b);
    endfunction

    // truncating mean, pinned at the top of the row range
    function automatic int unsigned mean_sat(logic [SUM_W-1:0] sum, logic [CNT_W-1:0] n);
        int unsigned q;
        q = 32'(sum) / 32'(n);
        return (q > 1023) ? 1023 : q;
    endfunction

    function automatic int unsigned mirror_col(int unsigned c);
        return (c > marker_regs.frame_width) ? 0 : marker_regs.frame_width - c;
    endfunction

    // Fold one pixel into the totals; on frame end build the centroids and clear
    function automatic bit track_pixel(input t_pix px, output t_result fr);
        int unsigned hr = 0;
        int unsigned hc = 0;
        int unsigned tr = 0;
        int unsigned tc = 0;
        bit          hf;
        bit          tf;
        fr = '0;
        if (px.pix_row < MAX_ROWS && px.pix_col < MAX_COLS) begin
            if (marker_hit(px, marker_regs.head_red, marker_regs.head_green,
                           marker_regs.head_blue)) begin
                frame_acc.head_row_sum += SUM_W'(px.pix_row);
                frame_acc.head_col_sum += SUM_W'(px.pix_col);
                frame_acc.head_count   += CNT_W'(1);
            end
            if (marker_hit(px, marker_regs.tail_red, marker_regs.tail_green,
                           marker_regs.tail_blue)) begin
                frame_acc.tail_row_sum += SUM_W'(px.pix_row);
                frame_acc.tail_col_sum += SUM_W'(px.pix_col);
                frame_acc.tail_count   += CNT_W'(1);
            end
        end
        if (!px.frame_end)
            return 1'b0;
        hf = (frame_acc.head_count != 0);
        tf = (frame_acc.tail_count != 0);
        if (hf) begin
            hr = mean_sat(frame_acc.head_row_sum, frame_acc.head_count);
            hc = mirror_col(mean_sat(frame_acc.head_col_sum, frame_acc.head_count));
        end
        if (tf) begin
            tr = mean_sat(frame_acc.tail_row_sum, frame_acc.tail_count);
            tc = mirror_col(mean_sat(frame_acc.tail_col_sum, frame_acc.tail_count));
        end
        fr.head_row   = hr[MEAN_W-1:0];
        fr.head_col   = hc[WIDTH_W-1:0];
        fr.tail_row   = tr[MEAN_W-1:0];
        fr.tail_col   = tc[WIDTH_W-1:0];
        fr.mid_row    = MEAN_W'((hr + tr) / 2);
        fr.mid_col    = WIDTH_W'((hc + tc) / 2);
        fr.head_found = hf;
        fr.tail_found = tf;
        frame_acc = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- result check

    function automatic void compare_frame(t_result want, t_result got);
        if (got.head_row !== want.head_row) begin
            $error("head_row: expected %0d, got %0d", want.head_row, got.head_row);
            faults++;
        end
        if (got.head_col !== want.head_col) begin
            $error("head_col: expected %0d, got %0d", want.head_col, got.head_col);
            faults++;
        end
        if (got.tail_row !== want.tail_row) begin
            $error("tail_row: expected %0d, got %0d", want.tail_row, got.tail_row);
            faults++;
        end
        if (got.tail_col !== want.tail_col) begin
            $error("tail_col: expected %0d, got %0d", want.tail_col, got.tail_col);
            faults++;
        end
        if (got.mid_row !== want.mid_row) begin
            $error("mid_row: expected %0d, got %0d", want.mid_row, got.mid_row);
            faults++;
        end
        if (got.mid_col !== want.mid_col) begin
            $error("mid_col: expected %0d, got %0d", want.mid_col, got.mid_col);
            faults++;
        end
        if (got.head_found !== want.head_found) begin
            $error("head_found: expected %0d, got %0d", want.head_found, got.head_found);
            faults++;
        end
        if (got.tail_found !== want.tail_found) begin
            $error("tail_found: expected %0d, got %0d", want.tail_found, got.tail_found);
            faults++;
        end
    endfunction

    // Take each popped beat against the oldest pending frame
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && o_empty === 1'b0) begin
            if (frame_results_q.size() == 0) begin
                $error("result beat with no frame pending: %p", o_res);
                faults++;
            end else begin
                compare_frame(frame_results_q.pop_front(), o_res);
                frames_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- pacing

    // mostly short gaps, a few long ones, now and then a run with none
    function automatic int unsigned idle_gap(inout int unsigned run_left);
        int unsigned r;
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            run_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random pops, plus one long hold on request
    initial begin
        int unsigned gap_left;
        int unsigned hold_left;
        int unsigned pop_run;
        gap_left  = 0;
        hold_left = 0;
        pop_run   = 0;
        i_pop     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pop_req) begin
                hold_pop_req = 1'b0;
                hold_left    = POP_HOLD;
            end
            if (!i_rst_n) begin
                i_pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop    <= 1'b1;
                gap_left = idle_gap(pop_run);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_pixel(t_pix px, bit typed, t_result want);
        t_result fr;
        bit      emits;
        i_pix  <= px;
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full !== 1'b0);
        emits = track_pixel(px, fr);
        pixels_sent++;
        if (emits) begin
            if (typed)
                fr = want;
            head_frames += fr.head_found;
            tail_frames += fr.tail_found;
            frame_results_q.insert(frame_results_q.size(), fr);
        end
    endtask

    task automatic pace_sender(inout int unsigned run_left);
        int unsigned gap;
        gap = idle_gap(run_left);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the input until every frame is back and the back end has settled
    task automatic drain();
        i_push <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_HEAD_RED:     marker_regs.head_red     = data[CHAN_W-1:0];
            REG_HEAD_GREEN:   marker_regs.head_green   = data[CHAN_W-1:0];
            REG_HEAD_BLUE:    marker_regs.head_blue    = data[CHAN_W-1:0];
            REG_TAIL_RED:     marker_regs.tail_red     = data[CHAN_W-1:0];
            REG_TAIL_GREEN:   marker_regs.tail_green   = data[CHAN_W-1:0];
            REG_TAIL_BLUE:    marker_regs.tail_blue    = data[CHAN_W-1:0];
            REG_MATCH_MARGIN: marker_regs.match_margin = data[MARGIN_W-1:0];
            REG_FRAME_WIDTH:  marker_regs.frame_width  = data[WIDTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(t_cfg c);
        write_reg(REG_HEAD_RED,     CFG_DATA_W'(c.head_red));
        write_reg(REG_HEAD_GREEN,   CFG_DATA_W'(c.head_green));
        write_reg(REG_HEAD_BLUE,    CFG_DATA_W'(c.head_blue));
        write_reg(REG_TAIL_RED,     CFG_DATA_W'(c.tail_red));
        write_reg(REG_TAIL_GREEN,   CFG_DATA_W'(c.tail_green));
        write_reg(REG_TAIL_BLUE,    CFG_DATA_W'(c.tail_blue));
        write_reg(REG_MATCH_MARGIN, CFG_DATA_W'(c.match_margin));
        write_reg(REG_FRAME_WIDTH,  CFG_DATA_W'(c.frame_width));
        i_cfg_we <= 1'b0;
    endtask

    // Marker settings per phase; a few phases pin the extremes
    function automatic t_cfg random_cfg(int unsigned kind);
        t_cfg c;
        c.head_red     = CHAN_W'($urandom_range(0, 255));
        c.head_green   = CHAN_W'($urandom_range(0, 255));
        c.head_blue    = CHAN_W'($urandom_range(0, 255));
        c.tail_red     = CHAN_W'($urandom_range(0, 255));
        c.tail_green   = CHAN_W'($urandom_range(0, 255));
        c.tail_blue    = CHAN_W'($urandom_range(0, 255));
        c.match_margin = MARGIN_W'($urandom_range(1, 64));
        c.frame_width  = WIDTH_W'($urandom_range(1, 1024));
        case (kind)
            0: begin
                c.match_margin = 9'd256;
                c.frame_width  = 11'd1024;
            end
            1: begin
                c.head_red = 8'd255; c.head_green = 8'd255; c.head_blue = 8'd255;
                c.tail_red = 8'd0;   c.tail_green = 8'd0;   c.tail_blue = 8'd0;
                c.match_margin = 9'd1;
                c.frame_width  = 11'd1;
            end
            5: c.match_margin = 9'd0;
            6: c.match_margin = MARGIN_W'($urandom_range(0, 256));
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] jitter(logic [CHAN_W-1:0] lvl, int span);
        int v;
        v = int'(lvl) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[CHAN_W-1:0];
    endfunction

    // Colors clustered around the markers, with some plain noise
    function automatic t_pix random_pixel(int unsigned end_odds);
        t_pix        px;
        int unsigned pick;
        int          span;
        span = (marker_regs.match_margin > 40) ? 40 : int'(marker_regs.match_margin) + 1;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            px.pix_red   = jitter(marker_regs.head_red, span);
            px.pix_green = jitter(marker_regs.head_green, span);
            px.pix_blue  = jitter(marker_regs.head_blue, span);
        end else if (pick < 75) begin
            px.pix_red   = jitter(marker_regs.tail_red, span);
            px.pix_green = jitter(marker_regs.tail_green, span);
            px.pix_blue  = jitter(marker_regs.tail_blue, span);
        end else begin
            px.pix_red   = CHAN_W'($urandom_range(0, 255));
            px.pix_green = CHAN_W'($urandom_range(0, 255));
            px.pix_blue  = CHAN_W'($urandom_range(0, 255));
        end
        px.pix_row   = ROW_W'($urandom_range(0, 1023));
        px.pix_col   = COL_W'($urandom_range(0, 1023));
        px.frame_end = ($urandom_range(0, end_odds) == 0);
        return px;
    endfunction

    function automatic void add_pix(int b, int g, int r, int row, int col, bit last);
        t_plan_row pr;
        pr.is_cfg        = 1'b0;
        pr.reg_idx       = REG_HEAD_RED;
        pr.reg_data      = '0;
        pr.px.pix_blue   = CHAN_W'(b);
        pr.px.pix_green  = CHAN_W'(g);
        pr.px.pix_red    = CHAN_W'(r);
        pr.px.pix_row    = ROW_W'(row);
        pr.px.pix_col    = COL_W'(col);
        pr.px.frame_end  = last;
        pr.typed         = 1'b0;
        pr.want          = '0;
        plan.insert(plan.size(), pr);
    endfunction

    function automatic void add_cfg(t_cfg_reg idx, int data);
        t_plan_row pr;
        pr.is_cfg   = 1'b1;
        pr.reg_idx  = idx;
        pr.reg_data = CFG_DATA_W'(data);
        pr.px       = '0;
        pr.typed    = 1'b0;
        pr.want     = '0;
        plan.insert(plan.size(), pr);
    endfunction

    function automatic void add_want(t_result w);
        plan[plan.size() - 1].typed = 1'b1;
        plan[plan.size() - 1].want  = w;
    endfunction

    function automatic void build_plan();
        // defaults after reset: both markers black, margin 16, width 640
        add_pix(0, 0, 0, 10, 20, 1);
        add_want('{head_row: 10, head_col: 620, tail_row: 10, tail_col: 620,
                   mid_row: 10, mid_col: 620, head_found: 1, tail_found: 1});
        add_pix(255, 255, 255, 1023, 1023, 1);
        add_want('0);
        // one inside the margin, one on its edge, then the far corner
        add_pix(15, 15, 15, 0, 0, 0);
        add_pix(16, 0, 0, 5, 5, 0);
        add_pix(0, 0, 15, 1023, 1023, 1);
        // distinct markers, zero margin: nothing can match
        add_cfg(REG_HEAD_RED, 200);
        add_cfg(REG_HEAD_GREEN, 100);
        add_cfg(REG_HEAD_BLUE, 50);
        add_cfg(REG_TAIL_RED, 30);
        add_cfg(REG_TAIL_GREEN, 220);
        add_cfg(REG_TAIL_BLUE, 128);
        add_cfg(REG_MATCH_MARGIN, 0);
        add_cfg(REG_FRAME_WIDTH, 1);
        add_pix(50, 100, 200, 7, 9, 1);
        add_want('0);
        // full margin: every pixel matches, column mirrors below zero
        add_cfg(REG_MATCH_MARGIN, 256);
        add_pix(255, 255, 255, 1023, 1023, 1);
        add_want('{head_row: 1023, head_col: 0, tail_row: 1023, tail_col: 0,
                   mid_row: 1023, mid_col: 0, head_found: 1, tail_found: 1});
        // exact colors only
        add_cfg(REG_MATCH_MARGIN, 1);
        add_pix(50, 100, 200, 4, 0, 0);
        add_pix(128, 220, 30, 6, 1, 1);
        // widest frame, margin 8
        add_cfg(REG_FRAME_WIDTH, 1024);
        add_cfg(REG_MATCH_MARGIN, 8);
        add_pix(57, 93, 207, 100, 300, 0);
        add_pix(58, 100, 200, 200, 200, 0);
        add_pix(121, 227, 23, 300, 1000, 0);
        add_pix(0, 0, 0, 0, 0, 1);
        // tail alone: midpoint comes from a zero head
        add_pix(128, 220, 30, 1, 2, 1);
    endfunction

    // ---------------------------------------------------------------- main flow

    initial begin
        int unsigned push_run;
        int unsigned end_odds;
        t_pix        px;
        push_run       = 0;
        faults         = 0;
        pixels_sent    = 0;
        frames_checked = 0;
        head_frames    = 0;
        tail_frames    = 0;
        cycle_count    = 0;
        hold_pop_req   = 1'b0;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_pix          = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        marker_regs    = '{head_red: 0, head_green: 0, head_blue: 0,
                           tail_red: 0, tail_green: 0, tail_blue: 0,
                           match_margin: 16, frame_width: 640};
        frame_acc      = '0;
        build_plan();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int k = 0; k < plan.size(); k++) begin
            if (plan[k].is_cfg) begin
                if (k == 0 || !plan[k - 1].is_cfg)
                    drain();
                write_reg(plan[k].reg_idx, plan[k].reg_data);
                if (k == plan.size() - 1 || !plan[k + 1].is_cfg)
                    i_cfg_we <= 1'b0;
            end else begin
                send_pixel(plan[k].px, plan[k].typed, plan[k].want);
                pace_sender(push_run);
            end
        end

        // Random phases, each under fresh marker settings
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            apply_cfg(random_cfg(ph));
            // phase 3 backs up the result side while frames keep closing
            if (ph == 3) begin
                hold_pop_req = 1'b1;
                end_odds     = 1;
            end else begin
                end_odds = $urandom_range(3, 20);
            end
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                px = random_pixel(end_odds);
                if (n == PHASE_PIXELS - 1)
                    px.frame_end = 1'b1;
                send_pixel(px, 1'b0, '0);
                pace_sender(push_run);
            end
        end

        drain();
        $display("Sent %0d pixels, checked %0d frame results across %0d marker setups",
                 pixels_sent, frames_checked, PHASES + 5);
        $display("Head seen in %0d frames, tail in %0d; %0d mismatches",
                 head_frames, tail_frames, faults);
        if (faults == 0 && frame_results_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
